>>> rtl/core/swes_pkg.sv
// Package with the shared types, constants and helpers of the single-wire EEPROM slave.
`timescale 1ns / 1ps

package swes_pkg;

  // Memory geometry.
  localparam int MEM_BYTES = 128;
  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam logic [8:0] MEM_LIMIT = 9'(MEM_BYTES);

  // Length of the manufacturer ID in bytes.
  localparam logic [7:0] ID_LEN = 8'd3;

  // Configuration port geometry.
  localparam int APB_AW = 5;

  // Register indexes.
  localparam logic [2:0] REG_RESET_LOW_MIN = 3'd0;
  localparam logic [2:0] REG_ONE_BIT_MAX = 3'd1;
  localparam logic [2:0] REG_DISC_HIGH_MIN = 3'd2;
  localparam logic [2:0] REG_DEVICE_SELECT = 3'd3;
  localparam logic [2:0] REG_ID_BYTES = 3'd4;

  // Register reset values.
  localparam logic [15:0] RST_RESET_LOW_MIN = 16'd100;
  localparam logic [15:0] RST_ONE_BIT_MAX = 16'd5;
  localparam logic [15:0] RST_DISC_HIGH_MIN = 16'd10;
  localparam logic [2:0] RST_DEVICE_SELECT = 3'd0;
  localparam logic [23:0] RST_ID_BYTES = 24'd54144;

  // Line event codes.
  localparam logic [2:0] FN_SLOT = 3'd0;
  localparam logic [2:0] FN_LOW_END = 3'd1;
  localparam logic [2:0] FN_TIMEOUT = 3'd2;
  localparam logic [2:0] FN_DISABLE = 3'd3;
  localparam logic [2:0] FN_PRELOAD = 3'd4;

  // Command opcodes.
  localparam logic [3:0] OPC_MEM = 4'hA;
  localparam logic [3:0] OPC_ID = 4'hC;

  typedef enum logic [2:0] {
    PH_RESET = 3'd0,
    PH_CMD   = 3'd1,
    PH_ADDR  = 3'd2,
    PH_DATA  = 3'd3,
    PH_TX    = 3'd4,
    PH_IDLE  = 3'd5
  } phase_t;

  // Outcome of stepping the transmit bit pointer.
  typedef struct packed {
    logic [7:0] byte_ptr;
    logic [7:0] bit_ptr;
    logic       pull;
    logic       ack;
  } adv_t;

  // A memory pointer past the end of the memory wraps to the first byte.
  function automatic logic [7:0] mem_wrap(input logic [7:0] p);
    mem_wrap = ({1'b0, p} >= MEM_LIMIT) ? 8'd0 : p;
  endfunction

endpackage

>>> rtl/core/swes_if.sv
// Valid/ready channel interfaces for line events and slot results.
`timescale 1ns / 1ps

interface swes_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [15:0] duration;
  logic [6:0] mem_addr;
  logic [7:0] load_data;

  modport source (output valid, func, duration, mem_addr, load_data, input ready);
  modport sink (input valid, func, duration, mem_addr, load_data, output ready);
endinterface

interface swes_result_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic [2:0] bus_state;

  modport source (output valid, drive_low, bus_state, input ready);
  modport sink (input valid, drive_low, bus_state, output ready);
endinterface

>>> rtl/core/swes_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module swes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/single_wire_eeprom_slave_top.sv
// Top level of the single-wire serial EEPROM slave.
`timescale 1ns / 1ps

// The block is the protocol engine of a single-wire EEPROM slave. A line
// front end measures the bus and hands it one transaction per line event on
// item_in: a slot start with the preceding high time, the end of a low pulse
// with its low time, a start/stop timeout, a disable, or a memory preload.
// For every event the block returns exactly one transaction on result_out:
// drive_low tells the front end whether to pull the line low in the slot
// that just started (only slot starts can set it), and bus_state is the
// protocol phase after the event.
// An event runs as a read step and an execute step: in the accept cycle the
// 128-byte memory is read at the byte the event may transmit, and once the
// output has room the event is executed with that byte and its result lands
// in the output register. A new event is taken only after the held one has
// executed; the registered read of the memory port makes this split needed.
// A finished result waits in the output register while the next event is
// already accepted and its memory read issued; only when that second event is
// ready to execute and the first result is still not taken does the block
// stall, and item_in.ready stays low until the receiver drains the output.
// Synchronous reset puts the bus in the idle phase, clears all pointers and
// flags and restores the configuration defaults. The memory itself is not
// cleared; bytes must be preloaded before they are read.
// Configuration goes through the APB port, one register per 32-bit word.
module single_wire_eeprom_slave_top (
  input  logic                          clk,
  input  logic                          rst,
  swes_item_if.sink                     item_in,
  swes_result_if.source                 result_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swes_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import swes_pkg::*;

  // Configuration registers.
  logic [15:0] reset_low_min;
  logic [15:0] one_bit_max;
  logic [15:0] disc_high_min;
  logic [2:0]  device_select;
  logic [23:0] id_bytes;

  // Protocol state.
  phase_t      phase, phase_next;
  logic [2:0]  bits_taken, bits_taken_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        pull_next, pull_next_next;
  logic        await_host_ack, await_host_ack_next;
  logic [7:0]  byte_pointer, byte_pointer_next;
  logic [7:0]  bit_pointer, bit_pointer_next;
  logic        source_is_id, source_is_id_next;

  // Event held between the read and execute cycles.
  logic        busy;
  logic [2:0]  it_func;
  logic [15:0] it_dur;
  logic [6:0]  it_addr;
  logic [7:0]  it_data;

  // Output register.
  logic        out_valid;
  logic        out_drive;
  phase_t      out_state;
  logic        drive;

  logic        accept;
  logic        exec;
  logic [7:0]  rd_ptr;
  logic [7:0]  rd_addr8;
  logic [7:0]  pre_addr8;
  logic        mem_we;
  logic [7:0]  mem_rdata;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic        low_bit;
  logic [7:0]  shifted;
  adv_t        adv;

  // One step of the transmit pointer. It wraps the byte pointer at the end of
  // the selected source, decides whether the next slot carries a zero bit,
  // and raises the host acknowledge window after the ACK slot.
  function automatic adv_t advance(input logic [7:0] bp_byte, input logic [7:0] bp_bit,
                                   input logic is_id, input logic [7:0] mem_byte,
                                   input logic [23:0] id);
    adv_t       a;
    logic [7:0] p;
    logic [7:0] id_byte;
    logic [7:0] src;
    p = is_id ? ((bp_byte >= ID_LEN) ? 8'd0 : bp_byte) : mem_wrap(bp_byte);
    case (p[1:0])
      2'd0:    id_byte = id[23:16];
      2'd1:    id_byte = id[15:8];
      default: id_byte = id[7:0];
    endcase
    src = is_id ? id_byte : mem_byte;
    a.byte_ptr = p;
    a.bit_ptr = bp_bit + 8'd1;
    a.pull = (bp_bit < 8'd8) && !src[~bp_bit[2:0]];
    a.ack = (bp_bit == 8'd9);
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_idx = paddr[APB_AW-1:2];
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_min <= RST_RESET_LOW_MIN;
      one_bit_max <= RST_ONE_BIT_MAX;
      disc_high_min <= RST_DISC_HIGH_MIN;
      device_select <= RST_DEVICE_SELECT;
      id_bytes <= RST_ID_BYTES;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RESET_LOW_MIN: reset_low_min <= pwdata[15:0];
        REG_ONE_BIT_MAX:   one_bit_max <= pwdata[15:0];
        REG_DISC_HIGH_MIN: disc_high_min <= pwdata[15:0];
        REG_DEVICE_SELECT: device_select <= pwdata[2:0];
        REG_ID_BYTES:      id_bytes <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RESET_LOW_MIN: prdata = {16'd0, reset_low_min};
      REG_ONE_BIT_MAX:   prdata = {16'd0, one_bit_max};
      REG_DISC_HIGH_MIN: prdata = {16'd0, disc_high_min};
      REG_DEVICE_SELECT: prdata = {29'd0, device_select};
      REG_ID_BYTES:      prdata = {8'd0, id_bytes};
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Accept and memory read. Only one event is in flight, so the state seen
  // here is final. An acknowledge from the host moves to the next byte, so a
  // low-ended event reads one byte ahead.
  // ---------------------------------------------------------------------------
  assign item_in.ready = !busy && !rst;
  assign accept = item_in.valid && item_in.ready;
  assign exec = busy && (!out_valid || result_out.ready);

  assign rd_ptr = (item_in.func == FN_LOW_END) ? (byte_pointer + 8'd1) : byte_pointer;
  assign rd_addr8 = mem_wrap(rd_ptr);
  assign pre_addr8 = {1'b0, it_addr};
  assign mem_we = exec && (it_func == FN_PRELOAD) && ({1'b0, pre_addr8} < MEM_LIMIT);

  swes_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(pre_addr8[MEM_AW-1:0]),
    .wdata(it_data),
    .re   (accept),
    .raddr(rd_addr8[MEM_AW-1:0]),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (exec) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_func <= item_in.func;
      it_dur <= item_in.duration;
      it_addr <= item_in.mem_addr;
      it_data <= item_in.load_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute: the protocol step for the held event.
  // ---------------------------------------------------------------------------
  assign low_bit = it_dur < one_bit_max;
  assign shifted = {shift_byte[6:0], low_bit};
  // A slot start advances at the current byte; an acknowledge advances at the
  // next byte with the bit pointer restarted.
  assign adv = (it_func == FN_LOW_END)
             ? advance(byte_pointer + 8'd1, 8'd0, source_is_id, mem_rdata, id_bytes)
             : advance(byte_pointer, bit_pointer, source_is_id, mem_rdata, id_bytes);

  always_comb begin
    phase_next = phase;
    bits_taken_next = bits_taken;
    shift_byte_next = shift_byte;
    pull_next_next = pull_next;
    await_host_ack_next = await_host_ack;
    byte_pointer_next = byte_pointer;
    bit_pointer_next = bit_pointer;
    source_is_id_next = source_is_id;
    drive = 1'b0;
    case (it_func)
      FN_SLOT: begin
        drive = pull_next;
        pull_next_next = 1'b0;
        if (phase == PH_TX) begin
          byte_pointer_next = adv.byte_ptr;
          bit_pointer_next = adv.bit_ptr;
          pull_next_next = adv.pull;
          if (adv.ack) begin
            await_host_ack_next = 1'b1;
          end
        end else if (phase == PH_RESET && it_dur >= disc_high_min) begin
          phase_next = PH_CMD;
          bits_taken_next = 3'd0;
          shift_byte_next = 8'd0;
        end
      end
      FN_LOW_END: begin
        if (it_dur > reset_low_min) begin
          phase_next = PH_RESET;
          bits_taken_next = 3'd0;
          shift_byte_next = 8'd0;
          pull_next_next = 1'b1;
          byte_pointer_next = 8'd0;
          bit_pointer_next = 8'd0;
        end else if (phase == PH_TX) begin
          if (await_host_ack) begin
            await_host_ack_next = 1'b0;
            if (!low_bit) begin
              byte_pointer_next = adv.byte_ptr;
              bit_pointer_next = adv.bit_ptr;
              pull_next_next = pull_next || adv.pull;
            end else begin
              phase_next = PH_CMD;
            end
          end
        end else if (bits_taken != 3'd7) begin
          shift_byte_next = shifted;
          bits_taken_next = bits_taken + 3'd1;
        end else begin
          bits_taken_next = 3'd0;
          shift_byte_next = 8'd0;
          if (phase == PH_CMD) begin
            if (shifted[3:1] == device_select) begin
              if (shifted[7:4] == OPC_ID) begin
                if (shifted[0]) begin
                  source_is_id_next = 1'b1;
                  bit_pointer_next = 8'd0;
                  byte_pointer_next = 8'd0;
                  phase_next = PH_TX;
                  pull_next_next = 1'b1;
                end
              end else if (shifted[7:4] == OPC_MEM) begin
                phase_next = shifted[0] ? PH_TX : PH_ADDR;
                source_is_id_next = 1'b0;
                bit_pointer_next = 8'd0;
                pull_next_next = 1'b1;
              end else begin
                phase_next = PH_IDLE;
              end
            end
          end else if (phase == PH_ADDR) begin
            byte_pointer_next = shifted;
            bit_pointer_next = 8'd0;
            phase_next = PH_CMD;
            pull_next_next = 1'b1;
          end
        end
      end
      FN_TIMEOUT: begin
        if (phase == PH_TX || phase == PH_ADDR || phase == PH_DATA) begin
          phase_next = PH_CMD;
          bits_taken_next = 3'd0;
          shift_byte_next = 8'd0;
        end
      end
      FN_DISABLE: begin
        phase_next = PH_IDLE;
        bits_taken_next = 3'd0;
        shift_byte_next = 8'd0;
        pull_next_next = 1'b0;
        byte_pointer_next = 8'd0;
        bit_pointer_next = 8'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bits_taken <= 3'd0;
      shift_byte <= 8'd0;
      pull_next <= 1'b0;
      await_host_ack <= 1'b0;
      byte_pointer <= 8'd0;
      bit_pointer <= 8'd0;
      source_is_id <= 1'b0;
    end else if (exec) begin
      phase <= phase_next;
      bits_taken <= bits_taken_next;
      shift_byte <= shift_byte_next;
      pull_next <= pull_next_next;
      await_host_ack <= await_host_ack_next;
      byte_pointer <= byte_pointer_next;
      bit_pointer <= bit_pointer_next;
      source_is_id <= source_is_id_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_drive <= drive;
      out_state <= phase_next;
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.drive_low = out_drive;
  assign result_out.bus_state = out_state;

endmodule

>>> rtl/core/swes_checker.sv
// Port-level assertions for the single-wire EEPROM slave, bound to the top level.
`timescale 1ns / 1ps

module swes_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       drive_low,
  input logic [2:0] bus_state
);

  // Only one event is in flight: after an accept the input closes.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // With room at the output at accept, a result follows its event after the read and execute steps.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(out_valid && !out_ready)) |=> ##1 out_valid)
    else $error("result missing two cycles after accept");

  // No result exists right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A reported phase is always a defined one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bus_state <= 3'd5))
    else $error("undefined bus state reported");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(drive_low) && $stable(bus_state)))
    else $error("stalled result changed");

endmodule

bind single_wire_eeprom_slave_top swes_checker u_swes_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (item_in.valid),
  .in_ready (item_in.ready),
  .out_valid(result_out.valid),
  .out_ready(result_out.ready),
  .drive_low(result_out.drive_low),
  .bus_state(result_out.bus_state)
);
